// File: src/mandelbrot_escape_time_unit_assert.svh
// Assertion macros for the escape-time unit.
`ifndef MANDELBROT_ESCAPE_TIME_UNIT_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_UNIT_ASSERT_SVH

// same-cycle implication
`define MBROT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbrot: same-cycle check failed");

// next-cycle implication
`define MBROT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbrot: next-cycle check failed");

`endif

// File: src/mbrot_pkg.sv
`default_nettype none

package mbrot_pkg;

    localparam int WORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 28;
    localparam int ITER_BITS_DEF  = 16;

    localparam int COORD_W   = 12;
    localparam int ITER_W    = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_X_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_START  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 3'd4;

    localparam logic signed [CFG_W-1:0] X_START_RST = -32'sd536870912;
    localparam logic signed [CFG_W-1:0] Y_START_RST = -32'sd300647710;
    localparam logic signed [CFG_W-1:0] X_STEP_RST  = 32'sd647501;
    localparam logic signed [CFG_W-1:0] Y_STEP_RST  = 32'sd587203;
    localparam logic [ITER_W-1:0]       MAX_ITER_RST = 16'd1000;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } mbrot_in_t;

    typedef struct packed {
        logic [ITER_W-1:0] iterations;
        logic              inside_res;
    } mbrot_out_t;

endpackage

`default_nettype wire

// File: src/mbrot_mul.sv
`default_nettype none

module mbrot_mul
    import mbrot_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic signed [WORD_WIDTH-1:0] a,
    input  wire logic signed [WORD_WIDTH-1:0] b,
    output logic signed [WORD_WIDTH-1:0]      prod_sh,
    output logic signed [WORD_WIDTH-1:0]      prod_sh2
);

    localparam int PW = 2 * WORD_WIDTH;
    localparam logic signed [WORD_WIDTH-1:0] WMAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam logic signed [WORD_WIDTH-1:0] WMIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] sh_f;
    logic signed [PW-1:0] sh_f1;

    function automatic logic signed [WORD_WIDTH-1:0] sat_w(input logic signed [PW-1:0] v);
        logic fits;
        fits = (&v[PW-1:WORD_WIDTH-1]) || (~|v[PW-1:WORD_WIDTH-1]);
        if (fits)
        begin
            sat_w = v[WORD_WIDTH-1:0];
        end
        else
        begin
            sat_w = v[PW-1] ? WMIN : WMAX;
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    // floor shifts: by FRAC_BITS, and by FRAC_BITS-1 for the doubled cross term
    assign sh_f     = prod_reg >>> FRAC_BITS;
    assign sh_f1    = prod_reg >>> (FRAC_BITS - 1);
    assign prod_sh  = sat_w(sh_f);
    assign prod_sh2 = sat_w(sh_f1);

endmodule

`default_nettype wire

// File: src/mandelbrot_escape_time_unit.sv
// Each pixel is mapped (ST_MAPY, ST_MAPC), then runs passes until it escapes or reaches its limit.
// A new pixel is taken only once the last is done; each pass runs ST_SQI, ST_CROSS, ST_ZI on the
// single shared multiplier (zr*zr, zi*zi, zr*zi). A pixel with limit 0 ends after mapping.
// The done beat lasts one cycle and cannot be stalled; start is taken when busy is low.
// Reset (rst_n low, async) clears control and loads the register defaults.
`default_nettype none

`include "mandelbrot_escape_time_unit_assert.svh"

module mandelbrot_escape_time_unit
    import mbrot_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ITER_BITS  = ITER_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire mbrot_in_t            pixel,
    output logic                      done,
    output mbrot_out_t                result,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int W    = WORD_WIDTH;
    localparam int CW   = (W + 2 > 47) ? W + 2 : 47;
    localparam int TW   = (W > FRAC_BITS + 3) ? W : FRAC_BITS + 3;
    localparam int MAPW = COORD_W + 1 + CFG_W;
    localparam int unsigned ITER_CAP = (1 << ITER_BITS) - 1;
    localparam logic [TW-1:0] FOUR = TW'(1) << (FRAC_BITS + 2);
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAPY  = 3'd1;
    localparam logic [2:0] ST_MAPC  = 3'd2;
    localparam logic [2:0] ST_SQI   = 3'd3;
    localparam logic [2:0] ST_CROSS = 3'd4;
    localparam logic [2:0] ST_ZI    = 3'd5;

    logic signed [CFG_W-1:0] x_start_reg, y_start_reg, x_step_reg, y_step_reg;
    logic [ITER_W-1:0]       max_iter_reg;

    logic [2:0]              state_reg, state_next;
    logic [COORD_W-1:0]      row_reg;
    logic signed [MAPW-1:0]  map_reg, map_next;
    logic signed [W-1:0]     cr_reg, ci_reg, zr_reg, zi_reg, sr_reg, si_reg;
    logic [ITER_BITS-1:0]    it_reg, lim_reg, lim_next;
    logic                    done_reg;
    mbrot_out_t              result_reg;

    logic                    accept;
    logic                    go;
    logic                    finish;
    logic [TW-1:0]           sq_sum;
    logic signed [W-1:0]     xs_cl, ys_cl;
    logic signed [W-1:0]     cr_next, ci_next, zr_next, zi_next;
    logic signed [W-1:0]     mul_a, mul_b, mul_sh, mul_sh2;
    logic                    mul_en;
    logic [COORD_W-1:0]      map_coord;
    logic signed [CFG_W-1:0] map_step;

    function automatic logic signed [W-1:0] clamp_w(input logic signed [CW-1:0] v);
        logic fits;
        fits = (&v[CW-1:W-1]) || (~|v[CW-1:W-1]);
        if (fits)
        begin
            clamp_w = v[W-1:0];
        end
        else
        begin
            clamp_w = v[CW-1] ? WMIN : WMAX;
        end
    endfunction

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_start_reg  <= X_START_RST;
            y_start_reg  <= Y_START_RST;
            x_step_reg   <= X_STEP_RST;
            y_step_reg   <= Y_STEP_RST;
            max_iter_reg <= MAX_ITER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_X_START:  x_start_reg  <= cfg_data;
                CFG_Y_START:  y_start_reg  <= cfg_data;
                CFG_X_STEP:   x_step_reg   <= cfg_data;
                CFG_Y_STEP:   y_step_reg   <= cfg_data;
                CFG_MAX_ITER: max_iter_reg <= cfg_data[ITER_W-1:0];
                default:      ;
            endcase
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign lim_next = ({16'd0, max_iter_reg} > 32'(ITER_CAP)) ? ITER_BITS'(ITER_CAP)
                                                             : ITER_BITS'(max_iter_reg);

    // coordinate mapping multiplier
    assign map_coord = (state_reg == ST_IDLE) ? pixel.col : row_reg;
    assign map_step  = (state_reg == ST_IDLE) ? x_step_reg : y_step_reg;
    assign map_next  = $signed({1'b0, map_coord}) * map_step;

    assign xs_cl   = clamp_w(CW'(x_start_reg));
    assign ys_cl   = clamp_w(CW'(y_start_reg));
    assign cr_next = clamp_w(CW'(xs_cl) + CW'(map_reg));
    assign ci_next = clamp_w(CW'(ys_cl) + CW'(map_reg));

    // shared multiplier operand select
    assign mul_en = busy;
    assign mul_a  = (state_reg == ST_SQI) ? zi_reg : zr_reg;
    assign mul_b  = (state_reg == ST_SQI || state_reg == ST_CROSS) ? zi_reg : zr_reg;

    mbrot_mul #(
        .WORD_WIDTH (W),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mul (
        .clk      (clk),
        .en       (mul_en),
        .a        (mul_a),
        .b        (mul_b),
        .prod_sh  (mul_sh),
        .prod_sh2 (mul_sh2)
    );

    assign zr_next = clamp_w(CW'(sr_reg) - CW'(mul_sh) + CW'(cr_reg));
    assign zi_next = clamp_w(CW'(mul_sh2) + CW'(ci_reg));

    // escape test on the previous pass's squares
    assign sq_sum = TW'(sr_reg[W-2:0]) + TW'(si_reg[W-2:0]);
    assign go     = (sq_sum <= FOUR) && (it_reg < lim_reg);
    assign finish = (state_reg == ST_MAPC || state_reg == ST_ZI) && !go;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  state_next = start ? ST_MAPY : ST_IDLE;
            ST_MAPY:  state_next = ST_MAPC;
            ST_MAPC:  state_next = go ? ST_SQI : ST_IDLE;
            ST_SQI:   state_next = ST_CROSS;
            ST_CROSS: state_next = ST_ZI;
            ST_ZI:    state_next = go ? ST_SQI : ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            it_reg    <= '0;
            lim_reg   <= '0;
            sr_reg    <= '0;
            si_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= finish;
            if (accept)
            begin
                it_reg  <= '0;
                lim_reg <= lim_next;
                sr_reg  <= '0;
                si_reg  <= '0;
            end
            else
            begin
                if (state_reg == ST_SQI)
                begin
                    sr_reg <= mul_sh;
                end
                if (state_reg == ST_CROSS)
                begin
                    si_reg <= mul_sh;
                    it_reg <= it_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg <= pixel.row;
            zr_reg  <= '0;
            zi_reg  <= '0;
        end
        if (accept || state_reg == ST_MAPY)
        begin
            map_reg <= map_next;
        end
        if (state_reg == ST_MAPY)
        begin
            cr_reg <= cr_next;
        end
        if (state_reg == ST_MAPC)
        begin
            ci_reg <= ci_next;
        end
        if (state_reg == ST_CROSS)
        begin
            zr_reg <= zr_next;
        end
        if (state_reg == ST_ZI)
        begin
            zi_reg <= zi_next;
        end
        if (finish)
        begin
            result_reg.iterations <= ITER_W'(it_reg);
            result_reg.inside_res <= (it_reg == lim_reg);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `MBROT_ASSERT_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg)
    `MBROT_ASSERT_NOW(a_done_idle, clk, rst_n, done_reg, state_reg == ST_IDLE)
    `MBROT_ASSERT_NOW(a_iter_bound, clk, rst_n, busy, it_reg <= lim_reg)
    `MBROT_ASSERT_NEXT(a_accept_init, clk, rst_n, accept,
                       state_reg == ST_MAPY && it_reg == '0)

endmodule

`default_nettype wire

// File: test/mandelbrot_escape_time_unit_tb.sv
`timescale 1ns / 1ps

module mandelbrot_escape_time_unit_tb;
    import mbrot_pkg::*;

    localparam longint W_MAX = (64'sd1 <<< (WORD_WIDTH_DEF - 1)) - 64'sd1;
    localparam longint W_MIN = -W_MAX - 64'sd1;
    localparam longint ESCAPE_R2 = 64'sd4 <<< FRAC_BITS_DEF;
    localparam int unsigned ITER_CAP = (1 << ITER_BITS_DEF) - 1;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_PHASES = 8;
    localparam int PIXELS_PER_PHASE = 75;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    mbrot_in_t pixel = '0;
    logic done;
    mbrot_out_t result;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    // shadow copy of the register file
    longint x_start_r = longint'(X_START_RST);
    longint y_start_r = longint'(Y_START_RST);
    longint x_step_r = longint'(X_STEP_RST);
    longint y_step_r = longint'(Y_STEP_RST);
    int unsigned max_iter_r = MAX_ITER_RST;

    mbrot_in_t pixel_queue[$];
    mbrot_out_t count_queue[$];

    logic held = 1'b0;
    int gap_left = 0;
    bit idle_en = 1'b1;
    bit hold = 1'b0;

    int mismatches = 0;
    int pixels_sent = 0;
    int results_seen = 0;
    int inside_seen = 0;
    int settings_used = 1;
    int cycles = 0;

    mandelbrot_escape_time_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .pixel    (pixel),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic longint sat_word(input longint v);
        if (v > W_MAX)
            return W_MAX;
        if (v < W_MIN)
            return W_MIN;
        return v;
    endfunction

    // exact product, floor shift, saturate
    function automatic longint fx_mul(input longint a, input longint b, input int sh);
        logic signed [127:0] p;
        logic signed [127:0] q;
        p = a;
        q = b;
        p = (p * q) >>> sh;
        if (p > W_MAX)
            return W_MAX;
        if (p < W_MIN)
            return W_MIN;
        return longint'(p);
    endfunction

    function automatic mbrot_out_t escape_count(input mbrot_in_t px);
        mbrot_out_t r;
        longint cr;
        longint ci;
        longint zr;
        longint zi;
        longint sr;
        longint si;
        longint nr;
        longint ni;
        int unsigned limit;
        int unsigned n;
        cr = sat_word(sat_word(x_start_r) + longint'(px.col) * x_step_r);
        ci = sat_word(sat_word(y_start_r) + longint'(px.row) * y_step_r);
        limit = (max_iter_r < ITER_CAP) ? max_iter_r : ITER_CAP;
        zr = 0;
        zi = 0;
        sr = 0;
        si = 0;
        n = 0;
        // escape test lags one pass behind the squares
        while (sr + si <= ESCAPE_R2 && n < limit)
        begin
            sr = fx_mul(zr, zr, FRAC_BITS_DEF);
            si = fx_mul(zi, zi, FRAC_BITS_DEF);
            nr = sat_word(sr - si + cr);
            ni = sat_word(fx_mul(zr, zi, FRAC_BITS_DEF - 1) + ci);
            zr = nr;
            zi = ni;
            n++;
        end
        r.iterations = n[ITER_W-1:0];
        r.inside_res = (n == limit);
        return r;
    endfunction

    task automatic report_error(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        case (idx)
            CFG_X_START:  x_start_r = longint'($signed(data));
            CFG_Y_START:  y_start_r = longint'($signed(data));
            CFG_X_STEP:   x_step_r = longint'($signed(data));
            CFG_Y_STEP:   y_step_r = longint'($signed(data));
            CFG_MAX_ITER: max_iter_r = data[ITER_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [CFG_W-1:0] xs, input logic [CFG_W-1:0] ys,
                             input logic [CFG_W-1:0] dx, input logic [CFG_W-1:0] dy,
                             input logic [CFG_W-1:0] lim);
        write_reg(CFG_X_START, xs);
        write_reg(CFG_Y_START, ys);
        write_reg(CFG_X_STEP, dx);
        write_reg(CFG_Y_STEP, dy);
        write_reg(CFG_MAX_ITER, lim);
        settings_used++;
    endtask

    function automatic bit in_flight();
        return held || start || busy || count_queue.size() != 0;
    endfunction

    // returns on a falling edge with the unit idle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pixel_queue.size() != 0 || in_flight());
    endtask

    task automatic push_pixel(input int c, input int r);
        mbrot_in_t px;
        px.col = c[COORD_W-1:0];
        px.row = r[COORD_W-1:0];
        pixel_queue.push_back(px);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        bit have;
        if (!rst_n)
        begin
            start <= 1'b0;
            pixel <= '0;
            held <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            have = held;
            if (start && !busy)
            begin
                count_queue.push_back(escape_count(pixel));
                pixels_sent++;
                have = 1'b0;
            end
            if (!have && !hold && pixel_queue.size() != 0)
            begin
                pixel <= pixel_queue.pop_front();
                have = 1'b1;
            end
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (have && idle_en && $urandom_range(0, 7) == 0)
            begin
                gap_left <= $urandom_range(0, 4);
                start <= 1'b0;
            end
            else
            begin
                start <= have;
            end
            held <= have;
        end
    end

    always @(posedge clk)
    begin : monitor
        mbrot_out_t want;
        if (rst_n && done)
        begin
            if (count_queue.size() == 0)
            begin
                report_error("done beat with no pixel outstanding");
            end
            else
            begin
                want = count_queue.pop_front();
                results_seen++;
                if (want.inside_res)
                    inside_seen++;
                if (result.iterations !== want.iterations)
                    report_error($sformatf("iterations got %0d want %0d",
                                           result.iterations, want.iterations));
                if (result.inside_res !== want.inside_res)
                    report_error($sformatf("inside_res got %b want %b",
                                           result.inside_res, want.inside_res));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAIL mandelbrot_escape_time_unit");
            $finish;
        end
    end

    initial
    begin
        int xs;
        int ys;
        int dx;
        int dy;
        int lim;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults: corners, plus a point near the origin that never escapes
        push_pixel(0, 0);
        push_pixel(4095, 4095);
        push_pixel(0, 4095);
        push_pixel(4095, 0);
        push_pixel(829, 512);
        wait_drained();

        // extreme registers, coordinates and z saturate
        configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 20);
        wait_drained();
        push_pixel(0, 0);
        push_pixel(4095, 4095);
        push_pixel(4095, 0);
        push_pixel(0, 4095);
        wait_drained();

        // zero limit
        configure(32'h0, 32'h0, 32'h0, 32'h0, 0);
        wait_drained();
        push_pixel(0, 0);
        push_pixel(4095, 4095);
        wait_drained();

        write_reg(CFG_MAX_ITER, 1);
        wait_drained();
        push_pixel(1, 1);
        wait_drained();

        // upper data bits dropped, out-of-range indexes ignored
        write_reg(CFG_MAX_ITER, 32'hABCD_0003);
        write_reg(3'd5, $urandom);
        write_reg(3'd6, $urandom);
        write_reg(3'd7, $urandom);
        wait_drained();
        push_pixel(5, 5);
        wait_drained();

        // c = -2 sits exactly on the escape radius
        configure(32'hE000_0000, 32'h0, 32'h0, 32'h0, 50);
        wait_drained();
        push_pixel(0, 0);
        wait_drained();

        // full counter at c = 0
        configure(32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_FFFF);
        wait_drained();
        push_pixel(0, 0);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                xs = $urandom;
                ys = $urandom;
                dx = $urandom;
                dy = $urandom;
            end
            else
            begin
                xs = -671088640 + int'($urandom_range(0, 805306368));
                ys = -402653184 + int'($urandom_range(0, 536870912));
                dx = $urandom_range(4096, 131072);
                dy = $urandom_range(4096, 131072);
                if ($urandom_range(0, 3) == 0)
                    dx = -dx;
                if ($urandom_range(0, 3) == 0)
                    dy = -dy;
            end
            lim = (p == 5) ? $urandom_range(100, 300) : $urandom_range(1, 64);
            configure(xs, ys, dx, dy, lim);
            wait_drained();
            idle_en = (p != RANDOM_PHASES - 1);
            for (int i = 0; i < PIXELS_PER_PHASE; i++)
                push_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
            if (p == 3)
            begin
                // hold the sender until everything in flight has come back
                while (pixel_queue.size() > PIXELS_PER_PHASE / 2)
                    @(negedge clk);
                hold = 1'b1;
                while (in_flight())
                    @(negedge clk);
                repeat ($urandom_range(1, 20)) @(negedge clk);
                hold = 1'b0;
            end
            wait_drained();
        end

        repeat (16) @(posedge clk);
        $display("run: %0d pixels over %0d register settings, %0d results, %0d inside",
                 pixels_sent, settings_used, results_seen, inside_seen);
        $display("run: zero and full limits, saturated coordinates, ignored indexes");
        if (mismatches == 0)
            $display("PASS mandelbrot_escape_time_unit");
        else
            $display("FAIL mandelbrot_escape_time_unit");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/mbrot_pkg.sv
src/mbrot_mul.sv
src/mandelbrot_escape_time_unit.sv
test/mandelbrot_escape_time_unit_tb.sv
